/* hdl/source_text_tokenizer_defines.svh */
// assertion macros for the tokenizer top level
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// same-cycle implication, held off during reset
`define STT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define STT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/stt_pkg.sv */
// types, token codes and character helpers of the source text tokenizer
package stt_pkg;

   localparam int BATCH_MAX = 8;
   localparam int Q_DEPTH   = 2;

   localparam logic [5:0] T_LPAREN    = 6'd0;
   localparam logic [5:0] T_RPAREN    = 6'd1;
   localparam logic [5:0] T_LBRACE    = 6'd2;
   localparam logic [5:0] T_RBRACE    = 6'd3;
   localparam logic [5:0] T_LBRACKET  = 6'd4;
   localparam logic [5:0] T_RBRACKET  = 6'd5;
   localparam logic [5:0] T_COMMA     = 6'd6;
   localparam logic [5:0] T_NEWLINE   = 6'd7;
   localparam logic [5:0] T_STRING    = 6'd8;
   localparam logic [5:0] T_EQ        = 6'd9;
   localparam logic [5:0] T_ASSIGN    = 6'd10;
   localparam logic [5:0] T_PLUSPLUS  = 6'd11;
   localparam logic [5:0] T_ARROW     = 6'd12;
   localparam logic [5:0] T_NUMBER    = 6'd13;
   localparam logic [5:0] T_AT_ARGS   = 6'd14;
   localparam logic [5:0] T_DIRECTIVE = 6'd15;
   localparam logic [5:0] T_DOT       = 6'd16;
   localparam logic [5:0] T_COLON     = 6'd17;
   localparam logic [5:0] T_DIV       = 6'd18;
   localparam logic [5:0] T_MOD       = 6'd19;
   localparam logic [5:0] T_ARGS      = 6'd20;
   localparam logic [5:0] T_IDENT     = 6'd21;
   localparam logic [5:0] T_KW0       = 6'd22;
   localparam logic [5:0] T_END       = 6'd34;

   localparam logic [47:0] ARGS_WIN = 48'("args");
   localparam logic [31:0] ARGS_TXT = "args";

   localparam logic [47:0] KW_WORD [12] = '{
      48'("func"), 48'("if"), 48'("else"), 48'("while"), 48'("break"), 48'("let"),
      48'("mut"), 48'("asm"), 48'("static"), 48'("return"), 48'("Format"),
      48'("UseLib")};
   localparam logic [2:0] KW_LEN [12] = '{
      3'd4, 3'd2, 3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6};

   typedef enum logic [3:0] {
      M_IDLE, M_ID, M_ID_LB, M_NUM, M_DQ, M_SQ, M_EQ1, M_PLUS1,
      M_MINUS1, M_DOT1, M_COLON1, M_LABEL, M_AT1, M_DIR_HOLD, M_DIR_LB, M_DIR_REST
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_byte;
      logic       token_end;
      logic [5:0] token_type;
   } item_type;

   typedef struct packed {
      item_type [BATCH_MAX-1:0] items;
      logic [3:0]               count;
   } batch_type;

   typedef struct packed {
      logic      valid;
      batch_type batch;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic     emit;
      item_type item;
      mode_type mode;
      logic     word;
   } idle_res_type;

   function automatic item_type mk_item(logic [7:0] b, logic has, logic e, logic [5:0] t);
      item_type it;
      it.text_byte  = has ? b : 8'd0;
      it.has_byte   = has;
      it.token_end  = e;
      it.token_type = e ? t : 6'd0;
      return it;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic [5:0] kw_type(logic [47:0] win, logic [2:0] len);
      logic [5:0] t;
      t = T_IDENT;
      for (int k = 11; k >= 0; k--) begin
         if (len == KW_LEN[k] && win == KW_WORD[k]) t = 6'(T_KW0 + k);
      end
      return t;
   endfunction

   // what a byte does when no token is open
   function automatic idle_res_type idle_fn(logic [7:0] c);
      idle_res_type r;
      r.emit = 1'b1;
      r.item = mk_item(c, 1'b1, 1'b0, 6'd0);
      r.mode = M_IDLE;
      r.word = 1'b0;
      case (c)
         " ", "\t", "\r": r.emit = 1'b0;
         "(":  r.item = mk_item(c, 1'b1, 1'b1, T_LPAREN);
         ")":  r.item = mk_item(c, 1'b1, 1'b1, T_RPAREN);
         "{":  r.item = mk_item(c, 1'b1, 1'b1, T_LBRACE);
         "}":  r.item = mk_item(c, 1'b1, 1'b1, T_RBRACE);
         "[":  r.item = mk_item(c, 1'b1, 1'b1, T_LBRACKET);
         "]":  r.item = mk_item(c, 1'b1, 1'b1, T_RBRACKET);
         ",":  r.item = mk_item(c, 1'b1, 1'b1, T_COMMA);
         "\n": r.item = mk_item(c, 1'b1, 1'b1, T_NEWLINE);
         "/":  r.item = mk_item(c, 1'b1, 1'b1, T_DIV);
         "%":  r.item = mk_item(c, 1'b1, 1'b1, T_MOD);
         "\"": r.mode = M_DQ;
         "'":  r.mode = M_SQ;
         "=":  r.mode = M_EQ1;
         "+":  r.mode = M_PLUS1;
         "-":  r.mode = M_MINUS1;
         ".":  r.mode = M_DOT1;
         ":":  r.mode = M_COLON1;
         "@": begin
            r.emit = 1'b0;
            r.mode = M_AT1;
         end
         default: begin
            if (is_digit(c)) begin
               r.mode = M_NUM;
            end else if (is_alpha(c) || c == "_") begin
               r.mode = M_ID;
               r.word = 1'b1;
            end else begin
               r.item = mk_item(c, 1'b1, 1'b1, T_IDENT);
            end
         end
      endcase
      return r;
   endfunction

endpackage

/* hdl/stt_req_if.sv */
// input channel: source bytes with end flag
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;

   modport source (output valid, source_byte, end_of_source, input ready);
   modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

/* hdl/stt_rsp_if.sv */
// result channel: token text bytes and token ends
interface stt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       token_end;
   logic [5:0] token_type;
   logic       last;

   modport source (output valid, text_byte, has_byte, token_end, token_type, last,
                   input ready);
   modport sink (input valid, text_byte, has_byte, token_end, token_type, last,
                 output ready);
endinterface

/* hdl/source_text_tokenizer.sv */
// Source text tokenizer: one source byte per req_chan transaction in, token text
// bytes and token ends out on rsp_chan, each with a type code (END closes the text).
// A req transaction carries source_byte and end_of_source; each one yields zero to
// seven rsp transactions, the final one flagged by last.
// The front lexer classifies a byte in the cycle it is taken and writes its whole
// batch of results into a two-entry queue; the back plays a batch out at one rsp
// transaction per cycle while rsp_chan.ready is high, from a registered output.
// Throughput: one req per cycle while every byte yields at most one result and
// rsp_chan.ready stays high; a byte that yields several results holds the back
// until all are played out, and the two-entry queue soaks up short bursts before
// req_chan.ready drops. The results of a byte pass through a queue entry and then
// the back's output register before they reach rsp_chan.
// Reset (synchronous, active high) returns the lexer to idle between tokens and
// empties the queue and the output register.
// When rsp_chan.ready is low the output holds its item, the queue fills and then
// req_chan.ready falls until space frees; nothing is dropped.
`include "source_text_tokenizer_defines.svh"
module source_text_tokenizer import stt_pkg::*; (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_chan,
   stt_rsp_if.source rsp_chan
);

   push_type     q_push;
   batch_type    q_head;
   q_status_type q_stat;
   logic         q_pop;

   stt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_stat.full),
      .push   (q_push)
   );

   stt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .pop    (q_pop),
      .head   (q_head),
      .status (q_stat)
   );

   stt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .status (q_stat),
      .pop    (q_pop),
      .rsp    (rsp_chan)
   );

   `STT_ASSERT_IMP(a_no_overflow, clock, reset, q_push.valid, !q_stat.full)
   `STT_ASSERT_IMP(a_status_sane, clock, reset, q_stat.full, !q_stat.empty)
   `STT_ASSERT_NXT(a_end_emits, clock, reset,
                   req_chan.valid && req_chan.ready && req_chan.end_of_source,
                   !q_stat.empty || rsp_chan.valid)

endmodule

/* hdl/stt_front.sv */
// front end: lexer state and per-byte classification into a batch of results
module stt_front import stt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   stt_req_if.sink  req,
   input  logic     q_full,
   output push_type push
);

   mode_type     mode_ff, mode_in;
   logic [47:0]  win_ff, win_in;
   logic [2:0]   len_ff, len_in;
   logic [3:0]   n;
   item_type [BATCH_MAX-1:0] items;
   logic [7:0]   c;
   logic         eos;
   logic         fire;
   logic         do_idle, do_rest, do_flush, do_hold, do_atargs, eos_dir;
   logic [2:0]   flush_cnt;
   idle_res_type idl;

   assign c         = req.source_byte;
   assign eos       = req.end_of_source;
   assign req.ready = !q_full;
   assign fire      = req.valid && req.ready;
   assign idl       = idle_fn(c);

   always_comb begin
      mode_in   = mode_ff;
      win_in    = win_ff;
      len_in    = len_ff;
      n         = 4'd0;
      items     = '0;
      do_idle   = 1'b0;
      do_rest   = 1'b0;
      do_flush  = 1'b0;
      do_hold   = 1'b0;
      do_atargs = 1'b0;
      eos_dir   = 1'b0;
      flush_cnt = 3'd0;
      if (eos) begin
         unique case (mode_ff)
            M_ID: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, kw_type(win_ff, len_ff)); n = n + 4'd1;
            end
            M_ID_LB: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_IDENT); n = n + 4'd1;
               items[n[2:0]] = mk_item("[", 1'b1, 1'b1, T_LBRACKET); n = n + 4'd1;
            end
            M_NUM: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_NUMBER); n = n + 4'd1;
            end
            M_DQ: begin
               items[n[2:0]] = mk_item("\"", 1'b1, 1'b1, T_STRING); n = n + 4'd1;
            end
            M_SQ: begin
               items[n[2:0]] = mk_item("'", 1'b1, 1'b1, T_STRING); n = n + 4'd1;
            end
            M_EQ1: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_ASSIGN); n = n + 4'd1;
            end
            M_PLUS1, M_MINUS1, M_LABEL: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_IDENT); n = n + 4'd1;
            end
            M_DOT1: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_DOT); n = n + 4'd1;
            end
            M_COLON1: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_COLON); n = n + 4'd1;
            end
            M_AT1: begin
               items[n[2:0]] = mk_item("@", 1'b1, 1'b1, T_IDENT); n = n + 4'd1;
            end
            M_DIR_HOLD, M_DIR_LB: begin
               do_flush = 1'b1;
               eos_dir  = 1'b1;
            end
            M_DIR_REST: begin
               items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_DIRECTIVE); n = n + 4'd1;
            end
            M_IDLE: ;
         endcase
      end else begin
         unique case (mode_ff)
            M_IDLE: do_idle = 1'b1;
            M_ID: begin
               if (is_word(c)) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  win_in = {win_ff[39:0], c};
                  len_in = (len_ff == 3'd7) ? len_ff : len_ff + 3'd1;
               end else if (c == "[" && len_ff == 3'd4 && win_ff == ARGS_WIN) begin
                  mode_in = M_ID_LB;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, kw_type(win_ff, len_ff));
                  n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_ID_LB: begin
               if (c == "]") begin
                  items[n[2:0]] = mk_item("[", 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  items[n[2:0]] = mk_item("]", 1'b1, 1'b1, T_ARGS); n = n + 4'd1;
                  mode_in = M_IDLE;
                  win_in  = '0;
                  len_in  = '0;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_IDENT); n = n + 4'd1;
                  items[n[2:0]] = mk_item("[", 1'b1, 1'b1, T_LBRACKET); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_NUM: begin
               if (is_digit(c)) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
               end else if (c == "h" || c == "H") begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b1, T_NUMBER); n = n + 4'd1;
                  mode_in = M_IDLE;
                  win_in  = '0;
                  len_in  = '0;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_NUMBER); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_DQ, M_SQ: begin
               if ((mode_ff == M_DQ && c == "\"") || (mode_ff == M_SQ && c == "'")) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b1, T_STRING); n = n + 4'd1;
                  mode_in = M_IDLE;
                  win_in  = '0;
                  len_in  = '0;
               end else begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
               end
            end
            M_EQ1, M_PLUS1: begin
               if ((mode_ff == M_EQ1 && c == "=") || (mode_ff == M_PLUS1 && c == "+")) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b1,
                                          (mode_ff == M_EQ1) ? T_EQ : T_PLUSPLUS);
                  n = n + 4'd1;
                  mode_in = M_IDLE;
                  win_in  = '0;
                  len_in  = '0;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1,
                                          (mode_ff == M_EQ1) ? T_ASSIGN : T_IDENT);
                  n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_MINUS1: begin
               if (c == ">") begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b1, T_ARROW); n = n + 4'd1;
                  mode_in = M_IDLE;
                  win_in  = '0;
                  len_in  = '0;
               end else if (is_digit(c)) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  mode_in = M_NUM;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_IDENT); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_DOT1: begin
               if (is_digit(c)) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  mode_in = M_NUM;
               end else if (is_alpha(c) || c == "_") begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  mode_in = M_LABEL;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_DOT); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_COLON1: begin
               if (is_alpha(c) || c == "_") begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  mode_in = M_LABEL;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_COLON); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_LABEL: begin
               if (is_word(c)) begin
                  items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
               end else begin
                  items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_IDENT); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_AT1: begin
               if (is_alpha(c)) begin
                  win_in  = '0;
                  len_in  = '0;
                  do_hold = 1'b1;
               end else begin
                  items[n[2:0]] = mk_item("@", 1'b1, 1'b1, T_IDENT); n = n + 4'd1;
                  do_idle = 1'b1;
               end
            end
            M_DIR_HOLD: do_hold = 1'b1;
            M_DIR_LB: begin
               do_flush = 1'b1;
               if (c == "]") begin
                  items[n[2:0]] = mk_item("@", 1'b1, 1'b0, 6'd0); n = n + 4'd1;
                  do_atargs = 1'b1;
               end else begin
                  do_rest = 1'b1;
               end
            end
            M_DIR_REST: do_rest = 1'b1;
         endcase
      end

      // directive word that may still turn into args
      if (do_hold) begin
         if (len_in < 3'd4) begin
            if (c == ARGS_TXT[8*(3-len_in[1:0]) +: 8]) begin
               win_in  = {win_in[39:0], c};
               len_in  = len_in + 3'd1;
               mode_in = M_DIR_HOLD;
            end else begin
               do_flush = 1'b1;
               do_rest  = 1'b1;
            end
         end else if (c == "[") begin
            mode_in = M_DIR_LB;
         end else begin
            do_flush = 1'b1;
            do_rest  = 1'b1;
         end
      end

      // release held directive bytes, oldest first
      if (do_flush) begin
         flush_cnt = (len_in > 3'd4) ? 3'd4 : len_in;
         for (int k = 3; k >= 0; k--) begin
            if (3'(k) < flush_cnt) begin
               items[n[2:0]] = mk_item(win_in[8*k +: 8], 1'b1, 1'b0, 6'd0); n = n + 4'd1;
            end
         end
         win_in = '0;
         len_in = '0;
      end

      if (do_atargs) begin
         items[n[2:0]] = mk_item("[", 1'b1, 1'b0, 6'd0); n = n + 4'd1;
         items[n[2:0]] = mk_item("]", 1'b1, 1'b1, T_AT_ARGS); n = n + 4'd1;
         mode_in = M_IDLE;
      end

      if (eos_dir) begin
         items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_DIRECTIVE); n = n + 4'd1;
      end

      if (do_rest) begin
         if (c == " " || c == "\t" || c == "{" || c == "\n" || c == "\r") begin
            items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_DIRECTIVE); n = n + 4'd1;
            do_idle = 1'b1;
         end else begin
            items[n[2:0]] = mk_item(c, 1'b1, 1'b0, 6'd0); n = n + 4'd1;
            mode_in = M_DIR_REST;
         end
      end

      // close done, byte starts over from idle
      if (do_idle) begin
         mode_in = idl.mode;
         win_in  = idl.word ? {40'd0, c} : 48'd0;
         len_in  = idl.word ? 3'd1 : 3'd0;
         if (idl.emit) begin
            items[n[2:0]] = idl.item; n = n + 4'd1;
         end
      end

      if (eos) begin
         items[n[2:0]] = mk_item(8'd0, 1'b0, 1'b1, T_END); n = n + 4'd1;
         mode_in = M_IDLE;
         win_in  = '0;
         len_in  = '0;
      end
   end

   assign push.valid       = fire && (n != 4'd0);
   assign push.batch.items = items;
   assign push.batch.count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         win_ff  <= '0;
         len_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         win_ff  <= win_in;
         len_ff  <= len_in;
      end
   end

endmodule

/* hdl/stt_queue.sv */
// two-entry batch queue between front and back
module stt_queue import stt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output batch_type    head,
   output q_status_type status
);

   batch_type  mem_ff [Q_DEPTH];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign do_push      = push.valid && (cnt_ff != 2'(Q_DEPTH));
   assign do_pop       = pop && (cnt_ff != 2'd0);
   assign head         = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == 2'(Q_DEPTH));
   assign status.empty = (cnt_ff == 2'd0);

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push.batch;
   end

endmodule

/* hdl/stt_back.sv */
// back end: plays out one batch, one result transaction per cycle while rsp.ready is high
module stt_back import stt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  batch_type    head,
   input  q_status_type status,
   output logic         pop,
   stt_rsp_if.source    rsp
);

   batch_type  cur_ff, cur_in;
   logic [2:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic       fire, at_last;
   item_type   it;

   assign fire    = rsp.valid && rsp.ready;
   assign at_last = (idx_ff == 3'(cur_ff.count - 4'd1));
   assign pop     = (!vld_ff || (fire && at_last)) && !status.empty;

   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (pop) begin
         cur_in = head;
         idx_in = 3'd0;
         vld_in = 1'b1;
      end else if (fire) begin
         if (at_last) vld_in = 1'b0;
         else idx_in = idx_ff + 3'd1;
      end
   end

   assign it             = cur_ff.items[idx_ff];
   assign rsp.valid      = vld_ff;
   assign rsp.text_byte  = it.text_byte;
   assign rsp.has_byte   = it.has_byte;
   assign rsp.token_end  = it.token_end;
   assign rsp.token_type = it.token_type;
   assign rsp.last       = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

/* verif/source_text_tokenizer_tb.sv */
// testbench for the source text tokenizer: directed and random byte streams checked against a lexer model
module source_text_tokenizer_tb;
   import stt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] sbyte;
      logic       eos;
   } src_item_type;

   typedef struct {
      logic [7:0] text_byte;
      logic       has_byte;
      logic       token_end;
      logic [5:0] token_type;
      logic       last;
   } tok_item_type;

   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset;

   stt_req_if req_chan ();
   stt_rsp_if rsp_chan ();

   source_text_tokenizer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // lexer model state
   mode_type    lx_mode;
   logic [47:0] lx_win;
   logic [2:0]  lx_len;

   src_item_type pending_src[$];
   tok_item_type expected_tokens[$];
   tok_item_type step_out[$];

   int  mismatches;
   int  idle_cycles;
   int  src_gap;
   int  rsp_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void emit(logic [7:0] b, logic has, logic e, logic [5:0] t);
      tok_item_type it;
      it.text_byte  = has ? b : 8'd0;
      it.has_byte   = has;
      it.token_end  = e;
      it.token_type = e ? t : 6'd0;
      it.last       = 1'b0;
      step_out.insert(step_out.size(), it);
   endfunction

   function automatic void lex_clear();
      lx_mode = M_IDLE;
      lx_win  = '0;
      lx_len  = '0;
   endfunction

   function automatic void win_add(logic [7:0] c);
      lx_win = {lx_win[39:0], c};
      if (lx_len < 3'd7) lx_len++;
   endfunction

   function automatic logic c_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic c_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic c_word(logic [7:0] c);
      return c_alpha(c) || c_digit(c) || c == "_";
   endfunction

   function automatic logic [5:0] word_kind();
      string kw[12] = '{"func", "if", "else", "while", "break", "let",
                        "mut", "asm", "static", "return", "Format", "UseLib"};
      logic [47:0] w;
      for (int k = 0; k < 12; k++) begin
         w = '0;
         for (int i = 0; i < kw[k].len(); i++) w = {w[39:0], kw[k][i]};
         if (lx_len == kw[k].len() && lx_win == w) return 6'(T_KW0 + k);
      end
      return T_IDENT;
   endfunction

   function automatic logic is_args_word();
      return lx_len == 3'd4 && lx_win == {16'd0, "args"};
   endfunction

   // held directive prefix, oldest byte first
   function automatic void release_window();
      int n;
      n = lx_len > 4 ? 4 : lx_len;
      for (int i = n; i > 0; i--) emit(lx_win[8*(i-1) +: 8], 1'b1, 1'b0, 6'd0);
      lx_win = '0;
      lx_len = '0;
   endfunction

   function automatic void lex_idle(logic [7:0] c);
      case (c)
         " ", "\t", "\r": ;
         "(":  emit(c, 1'b1, 1'b1, T_LPAREN);
         ")":  emit(c, 1'b1, 1'b1, T_RPAREN);
         "{":  emit(c, 1'b1, 1'b1, T_LBRACE);
         "}":  emit(c, 1'b1, 1'b1, T_RBRACE);
         "[":  emit(c, 1'b1, 1'b1, T_LBRACKET);
         "]":  emit(c, 1'b1, 1'b1, T_RBRACKET);
         ",":  emit(c, 1'b1, 1'b1, T_COMMA);
         "\n": emit(c, 1'b1, 1'b1, T_NEWLINE);
         "/":  emit(c, 1'b1, 1'b1, T_DIV);
         "%":  emit(c, 1'b1, 1'b1, T_MOD);
         "\"": begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_DQ; end
         "'":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_SQ; end
         "=":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_EQ1; end
         "+":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_PLUS1; end
         "-":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_MINUS1; end
         ".":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_DOT1; end
         ":":  begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_COLON1; end
         "@":  lx_mode = M_AT1;
         default: begin
            if (c_digit(c)) begin
               emit(c, 1'b1, 1'b0, 6'd0);
               lx_mode = M_NUM;
            end else if (c_alpha(c) || c == "_") begin
               emit(c, 1'b1, 1'b0, 6'd0);
               lx_win = '0;
               lx_len = '0;
               win_add(c);
               lx_mode = M_ID;
            end else begin
               emit(c, 1'b1, 1'b1, T_IDENT);
            end
         end
      endcase
   endfunction

   function automatic void close_and_restart(logic [5:0] t, logic [7:0] c);
      emit(8'd0, 1'b0, 1'b1, t);
      lex_clear();
      lex_idle(c);
   endfunction

   function automatic void directive_body(logic [7:0] c);
      if (c == " " || c == "\t" || c == "{" || c == "\n" || c == "\r") begin
         close_and_restart(T_DIRECTIVE, c);
      end else begin
         emit(c, 1'b1, 1'b0, 6'd0);
         lx_mode = M_DIR_REST;
      end
   endfunction

   function automatic void directive_prefix(logic [7:0] c);
      logic [31:0] argw;
      argw = "args";
      if (lx_len < 3'd4) begin
         if (c == argw[8*(3-lx_len) +: 8]) begin
            win_add(c);
            lx_mode = M_DIR_HOLD;
         end else begin
            release_window();
            directive_body(c);
         end
      end else if (c == "[") begin
         lx_mode = M_DIR_LB;
      end else begin
         release_window();
         directive_body(c);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      case (lx_mode)
         M_IDLE: lex_idle(c);
         M_ID: begin
            if (c_word(c)) begin
               emit(c, 1'b1, 1'b0, 6'd0);
               win_add(c);
            end else if (c == "[" && is_args_word()) begin
               lx_mode = M_ID_LB;
            end else begin
               close_and_restart(word_kind(), c);
            end
         end
         M_ID_LB: begin
            if (c == "]") begin
               emit("[", 1'b1, 1'b0, 6'd0);
               emit("]", 1'b1, 1'b1, T_ARGS);
               lex_clear();
            end else begin
               emit(8'd0, 1'b0, 1'b1, T_IDENT);
               emit("[", 1'b1, 1'b1, T_LBRACKET);
               lex_clear();
               lex_idle(c);
            end
         end
         M_NUM: begin
            if (c_digit(c)) emit(c, 1'b1, 1'b0, 6'd0);
            else if (c == "h" || c == "H") begin
               emit(c, 1'b1, 1'b1, T_NUMBER);
               lex_clear();
            end else close_and_restart(T_NUMBER, c);
         end
         M_DQ: begin
            if (c == "\"") begin emit(c, 1'b1, 1'b1, T_STRING); lex_clear(); end
            else emit(c, 1'b1, 1'b0, 6'd0);
         end
         M_SQ: begin
            if (c == "'") begin emit(c, 1'b1, 1'b1, T_STRING); lex_clear(); end
            else emit(c, 1'b1, 1'b0, 6'd0);
         end
         M_EQ1: begin
            if (c == "=") begin emit(c, 1'b1, 1'b1, T_EQ); lex_clear(); end
            else close_and_restart(T_ASSIGN, c);
         end
         M_PLUS1: begin
            if (c == "+") begin emit(c, 1'b1, 1'b1, T_PLUSPLUS); lex_clear(); end
            else close_and_restart(T_IDENT, c);
         end
         M_MINUS1: begin
            if (c == ">") begin emit(c, 1'b1, 1'b1, T_ARROW); lex_clear(); end
            else if (c_digit(c)) begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_NUM; end
            else close_and_restart(T_IDENT, c);
         end
         M_DOT1: begin
            if (c_digit(c)) begin emit(c, 1'b1, 1'b0, 6'd0); lx_mode = M_NUM; end
            else if (c_alpha(c) || c == "_") begin
               emit(c, 1'b1, 1'b0, 6'd0);
               lx_mode = M_LABEL;
            end
            else close_and_restart(T_DOT, c);
         end
         M_COLON1: begin
            if (c_alpha(c) || c == "_") begin
               emit(c, 1'b1, 1'b0, 6'd0);
               lx_mode = M_LABEL;
            end
            else close_and_restart(T_COLON, c);
         end
         M_LABEL: begin
            if (c_word(c)) emit(c, 1'b1, 1'b0, 6'd0);
            else close_and_restart(T_IDENT, c);
         end
         M_AT1: begin
            if (c_alpha(c)) begin
               lx_win = '0;
               lx_len = '0;
               directive_prefix(c);
            end else begin
               emit("@", 1'b1, 1'b1, T_IDENT);
               lex_clear();
               lex_idle(c);
            end
         end
         M_DIR_HOLD: directive_prefix(c);
         M_DIR_LB: begin
            if (c == "]") begin
               emit("@", 1'b1, 1'b0, 6'd0);
               release_window();
               emit("[", 1'b1, 1'b0, 6'd0);
               emit("]", 1'b1, 1'b1, T_AT_ARGS);
               lex_clear();
            end else begin
               release_window();
               directive_body(c);
            end
         end
         M_DIR_REST: directive_body(c);
         default: begin lex_clear(); lex_idle(c); end
      endcase
   endfunction

   function automatic void lex_flush();
      case (lx_mode)
         M_ID: emit(8'd0, 1'b0, 1'b1, word_kind());
         M_ID_LB: begin
            emit(8'd0, 1'b0, 1'b1, T_IDENT);
            emit("[", 1'b1, 1'b1, T_LBRACKET);
         end
         M_NUM: emit(8'd0, 1'b0, 1'b1, T_NUMBER);
         M_DQ: emit("\"", 1'b1, 1'b1, T_STRING);
         M_SQ: emit("'", 1'b1, 1'b1, T_STRING);
         M_EQ1: emit(8'd0, 1'b0, 1'b1, T_ASSIGN);
         M_PLUS1, M_MINUS1, M_LABEL: emit(8'd0, 1'b0, 1'b1, T_IDENT);
         M_DOT1: emit(8'd0, 1'b0, 1'b1, T_DOT);
         M_COLON1: emit(8'd0, 1'b0, 1'b1, T_COLON);
         M_AT1: emit("@", 1'b1, 1'b1, T_IDENT);
         M_DIR_HOLD, M_DIR_LB: begin
            release_window();
            emit(8'd0, 1'b0, 1'b1, T_DIRECTIVE);
         end
         M_DIR_REST: emit(8'd0, 1'b0, 1'b1, T_DIRECTIVE);
         default: ;
      endcase
      emit(8'd0, 1'b0, 1'b1, T_END);
      lex_clear();
   endfunction

   function automatic void predict_tokens(src_item_type s);
      step_out.delete();
      if (s.eos) lex_flush();
      else lex_byte(s.sbyte);
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_tokens.insert(expected_tokens.size(), step_out[i]);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic queue_text(string s);
      src_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.sbyte = s[i];
         it.eos   = 1'b0;
         pending_src.insert(pending_src.size(), it);
      end
   endtask

   task automatic queue_end();
      src_item_type it;
      it.sbyte = 8'($urandom);
      it.eos   = 1'b1;
      pending_src.insert(pending_src.size(), it);
   endtask

   task automatic queue_byte(logic [7:0] b);
      src_item_type it;
      it.sbyte = b;
      it.eos   = 1'b0;
      pending_src.insert(pending_src.size(), it);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // hold the offered transaction
      end else if (src_gap > 0) begin
         src_gap <= src_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_src.size() > 0) begin
         src_item_type it;
         it = pending_src.pop_front();
         req_chan.valid         <= 1'b1;
         req_chan.source_byte   <= it.sbyte;
         req_chan.end_of_source <= it.eos;
         src_gap <= pick_gap();
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            src_item_type s;
            s.sbyte = req_chan.source_byte;
            s.eos   = req_chan.end_of_source;
            predict_tokens(s);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected token transaction: byte %h type %0d",
                           rsp_chan.text_byte, rsp_chan.token_type);
            end else begin
               tok_item_type e;
               e = expected_tokens.pop_front();
               if (rsp_chan.text_byte !== e.text_byte || rsp_chan.has_byte !== e.has_byte ||
                   rsp_chan.token_end !== e.token_end ||
                   rsp_chan.token_type !== e.token_type || rsp_chan.last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("token mismatch: exp %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                              e.text_byte, e.has_byte, e.token_end, e.token_type, e.last,
                              rsp_chan.text_byte, rsp_chan.has_byte, rsp_chan.token_end,
                              rsp_chan.token_type, rsp_chan.last);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("source_text_tokenizer_tb: done, errors");
         $finish;
      end
   end

   initial begin
      string frags[] = {"func", "if", "else", "while", "break", "let", "mut", "asm",
                        "static", "return", "Format", "UseLib", "args[]", "args[x",
                        "argsy", "@args[]", "@args[x", "@arg ", "@dir{", "@x\n", "@1",
                        "12h", "-7", ".5", "->", "++", "+x", "==", "=a", ":lab", ".lbl",
                        "\"str\"", "'s'", "(", ")", "{", "}", "[", "]", ",", "/", "%",
                        " ", "\t", "\r", "\n", "abc_9", "funcs", "@", ":", "."};
      string s;
      int n;
      mismatches  = 0;
      idle_cycles = 0;
      src_gap     = 0;
      rsp_gap     = 0;
      lex_clear();
      req_chan.valid         = 1'b0;
      req_chan.source_byte   = 8'd0;
      req_chan.end_of_source = 1'b0;
      rsp_chan.ready         = 1'b0;
      reset = 1'b1;

      // directed: constructs, extremes, an unclosed quote and an unclosed directive at the end
      queue_end();
      queue_text("@args[]args[]x12h");
      queue_end();
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(8'h80);
      queue_text("\"ab");
      queue_end();
      queue_text("@ar[");
      queue_end();

      // random: mostly well-formed fragments, some raw noise
      n = 0;
      while (n < 240) begin
         if ($urandom_range(0, 9) < 7) begin
            s = frags[$urandom_range(0, frags.size() - 1)];
            queue_text(s);
            n += s.len();
         end else begin
            queue_byte(8'($urandom));
            n++;
         end
         if ($urandom_range(0, 19) == 0) begin
            queue_end();
            n++;
         end
      end
      queue_end();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_src.size() == 0 && !req_chan.valid);
      wait (expected_tokens.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("source_text_tokenizer_tb: done, clean");
      else
         $display("source_text_tokenizer_tb: done, errors");
      $finish;
   end

endmodule
